// ----- sv/pee_pkg.sv -----
// Shared types and constants of the postfix expression evaluator.
package pee_pkg;

   localparam logic [7:0] SymOpen  = 8'h5B;
   localparam logic [7:0] SymClose = 8'h5D;
   localparam logic [7:0] SymAdd   = 8'h2B;
   localparam logic [7:0] SymSub   = 8'h2D;
   localparam logic [7:0] SymMul   = 8'h2A;
   localparam logic [7:0] SymDiv   = 8'h2F;
   localparam logic [7:0] SymMod   = 8'h25;
   localparam logic [7:0] SymPow   = 8'h5E;
   localparam logic [7:0] SymEnd   = 8'h00;
   localparam logic [31:0] PopEmpty = 32'hFFFF_FFFF;

   // controller to datapath
   typedef struct packed {
      logic load_sym;    // capture input symbol
      logic frame_step;  // handle a byte inside/opening a frame
      logic pop_right;   // pop into right operand
      logic pop_left;    // pop into left operand
      logic start_alu;   // start operator on left/right
      logic push_res;    // push operator result
      logic pop_answer;  // pop final answer
      logic clear_expr;  // end of expression clear
   } pee_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic frame_byte;  // symbol is consumed by framing
      logic is_end;      // symbol is zero
      logic alu_done;    // iterative unit finished
   } pee_status_type;

endpackage

// ----- sv/pee_datapath.sv -----
// Datapath: operand stack, number framing, error flags and iterative ALU.
module pee_datapath
   import pee_pkg::*;
#(
   parameter int STACK_DEPTH = 16
) (
   input  logic           clock,
   input  logic           reset,
   input  logic [7:0]     symbol,
   input  pee_cmd_type    cmd,
   output pee_status_type status,
   output logic [31:0]    answer,
   output logic [2:0]     flags
);

   localparam int PtrW = $clog2(STACK_DEPTH);
   localparam int CntW = $clog2(STACK_DEPTH + 1);
   localparam logic [CntW-1:0] DepthC = CntW'(STACK_DEPTH);

   logic [31:0] stack_mem [STACK_DEPTH];
   logic [CntW-1:0] count_ff, count_in;
   logic [7:0]  sym_ff;
   logic [31:0] num_ff, num_in;
   logic        inbr_ff, inbr_in, stop_ff, stop_in;
   logic [2:0]  err_ff, err_in;
   logic [31:0] left_ff, right_ff;
   logic [PtrW-1:0] rd_addr;
   logic        empty, full;
   logic        op_known;

   assign empty   = (count_ff == '0);
   assign full    = (count_ff >= DepthC);
   assign rd_addr = PtrW'(count_ff - CntW'(1));

   // unknown bytes pop their operands and push nothing
   assign op_known = sym_ff inside {SymAdd, SymSub, SymMul, SymDiv, SymMod, SymPow};

   // ------------------------------------------------------------------
   // iterative unit: restoring divider and square-and-multiply power
   logic [5:0]  it_ff, it_in;
   logic        busy_ff, busy_in, done_ff, done_in;
   logic [31:0] rem_ff, rem_in, quo_ff, quo_in;   // divider, or acc/sq for power
   logic [31:0] dvs_ff, dvs_in, exp_ff, exp_in;
   logic [31:0] res_ff, res_in;
   logic        qneg_ff, qneg_in, rneg_ff, rneg_in, isdiv_ff, isdiv_in;
   logic [32:0] trial;
   logic [31:0] nrem, acc_mul, sq_mul;
   logic [31:0] abs_l, abs_r;

   assign abs_l = left_ff[31]  ? 32'(-left_ff)  : left_ff;
   assign abs_r = right_ff[31] ? 32'(-right_ff) : right_ff;
   assign nrem  = {rem_ff[30:0], quo_ff[31]};
   assign trial = {1'b0, nrem} - {1'b0, dvs_ff};
   assign acc_mul = rem_ff * quo_ff;
   assign sq_mul  = quo_ff * quo_ff;

   always_comb begin
      it_in = it_ff; busy_in = busy_ff; done_in = 1'b0;
      rem_in = rem_ff; quo_in = quo_ff; dvs_in = dvs_ff; exp_in = exp_ff;
      res_in = res_ff; qneg_in = qneg_ff; rneg_in = rneg_ff; isdiv_in = isdiv_ff;
      err_in = err_ff;
      if (cmd.start_alu) begin
         busy_in = 1'b0; done_in = 1'b1; isdiv_in = 1'b0;
         case (sym_ff)
            SymAdd: res_in = left_ff + right_ff;
            SymSub: res_in = left_ff - right_ff;
            SymMul: res_in = left_ff * right_ff;
            SymDiv, SymMod: begin
               if (right_ff == '0) begin
                  res_in = '0; err_in[2] = 1'b1;
               end else begin
                  busy_in = 1'b1; done_in = 1'b0; isdiv_in = 1'b1;
                  rem_in = '0; quo_in = abs_l; dvs_in = abs_r; it_in = '0;
                  qneg_in = left_ff[31] ^ right_ff[31]; rneg_in = left_ff[31];
               end
            end
            SymPow: begin
               if (right_ff[31]) begin
                  if (left_ff == 32'd1) res_in = 32'd1;
                  else if (left_ff == PopEmpty)
                     res_in = right_ff[0] ? PopEmpty : 32'd1;
                  else res_in = '0;
               end else begin
                  busy_in = 1'b1; done_in = 1'b0;
                  rem_in = 32'd1; quo_in = left_ff; exp_in = right_ff; it_in = '0;
               end
            end
            default: res_in = '0;
         endcase
      end else if (busy_ff) begin
         it_in = it_ff + 6'd1;
         if (isdiv_ff) begin
            // one quotient bit a cycle
            if (!trial[32]) begin
               rem_in = trial[31:0]; quo_in = {quo_ff[30:0], 1'b1};
            end else begin
               rem_in = nrem; quo_in = {quo_ff[30:0], 1'b0};
            end
            if (it_ff == 6'd31) begin
               busy_in = 1'b0; done_in = 1'b1;
               if (sym_ff == SymDiv) res_in = qneg_ff ? 32'(-quo_in) : quo_in;
               else res_in = rneg_ff ? 32'(-rem_in) : rem_in;
            end
         end else begin
            // one exponent bit a cycle
            if (exp_ff[0]) rem_in = acc_mul;
            quo_in = sq_mul;
            exp_in = exp_ff >> 1;
            if (exp_ff == '0) begin
               busy_in = 1'b0; done_in = 1'b1; res_in = rem_ff;
               rem_in = rem_ff;
            end
         end
      end
      // stack errors and clears
      if ((cmd.pop_right || cmd.pop_left || cmd.pop_answer) && empty) err_in[0] = 1'b1;
      if (cmd.push_res && op_known && full) err_in[1] = 1'b1;
      if (cmd.frame_step && inbr_ff && sym_ff == SymClose && full) err_in[1] = 1'b1;
      if (cmd.clear_expr) err_in = '0;
   end

   // ------------------------------------------------------------------
   // framing and stack count
   always_comb begin
      num_in = num_ff; inbr_in = inbr_ff; stop_in = stop_ff; count_in = count_ff;
      if (cmd.frame_step) begin
         if (inbr_ff) begin
            if (sym_ff == SymClose) begin
               if (!full) count_in = count_ff + CntW'(1);
               inbr_in = 1'b0; num_in = '0; stop_in = 1'b0;
            end else if (!stop_ff && sym_ff inside {[8'h30:8'h39]}) begin
               num_in = 32'(num_ff * 32'd10) + {28'd0, sym_ff[3:0]};
            end else begin
               stop_in = 1'b1;
            end
         end else begin
            inbr_in = 1'b1; num_in = '0; stop_in = 1'b0;
         end
      end
      if ((cmd.pop_right || cmd.pop_left) && !empty) count_in = count_ff - CntW'(1);
      if (cmd.push_res && op_known && !full) count_in = count_ff + CntW'(1);
      if (cmd.clear_expr) begin
         count_in = '0; num_in = '0; inbr_in = 1'b0; stop_in = 1'b0;
      end
   end

   assign status.frame_byte = inbr_ff || (sym_ff == SymOpen);
   assign status.is_end     = (sym_ff == SymEnd);
   assign status.alu_done   = done_ff;
   assign answer = left_ff;
   assign flags  = err_ff;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0; num_ff <= '0; inbr_ff <= 1'b0; stop_ff <= 1'b0;
         err_ff <= '0; busy_ff <= 1'b0; done_ff <= 1'b0; it_ff <= '0;
      end else begin
         count_ff <= count_in; num_ff <= num_in; inbr_ff <= inbr_in;
         stop_ff <= stop_in; err_ff <= err_in; busy_ff <= busy_in;
         done_ff <= done_in; it_ff <= it_in;
      end
   end

   // payload registers and stack memory
   always_ff @(posedge clock) begin
      rem_ff <= rem_in; quo_ff <= quo_in; dvs_ff <= dvs_in; exp_ff <= exp_in;
      res_ff <= res_in; qneg_ff <= qneg_in; rneg_ff <= rneg_in; isdiv_ff <= isdiv_in;
      if (cmd.load_sym) sym_ff <= symbol;
      if (cmd.pop_right) right_ff <= empty ? PopEmpty : stack_mem[rd_addr];
      if (cmd.pop_left || cmd.pop_answer) left_ff <= empty ? PopEmpty : stack_mem[rd_addr];
      if (cmd.push_res && op_known && !full) stack_mem[PtrW'(count_ff)] <= res_ff;
      if (cmd.frame_step && inbr_ff && sym_ff == SymClose && !full)
         stack_mem[PtrW'(count_ff)] <= num_ff;
   end

   // the count never exceeds the depth
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DepthC) else $error("stack count beyond depth");
   // a clear leaves the stack empty with no flags
   a_clear: assert property (@(posedge clock) disable iff (reset)
      cmd.clear_expr |=> (count_ff == '0 && err_ff == '0)) else $error("clear failed");
   // the unit never signals done while busy
   a_done: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff) else $error("done while busy");

endmodule

// ----- sv/pee_ctrl.sv -----
// Controller: sequences one input item through framing, pops, ALU and push, or the final pop and result.
module pee_ctrl
   import pee_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   input  pee_status_type status,
   output pee_cmd_type    cmd
);

   localparam logic [2:0] StIdle  = 3'd0;
   localparam logic [2:0] StDec   = 3'd1;
   localparam logic [2:0] StLeft  = 3'd2;
   localparam logic [2:0] StAlu   = 3'd3;
   localparam logic [2:0] StWait  = 3'd4;
   localparam logic [2:0] StEnd   = 3'd5;
   localparam logic [2:0] StOut   = 3'd6;

   logic [2:0] state_ff, state_in;

   assign req_ready = (state_ff == StIdle);
   assign rsp_valid = (state_ff == StOut);

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      case (state_ff)
         StIdle: if (req_valid) begin
            cmd.load_sym = 1'b1; state_in = StDec;
         end
         StDec: begin
            if (status.is_end) begin
               cmd.pop_answer = 1'b1; state_in = StEnd;
            end else if (status.frame_byte) begin
               cmd.frame_step = 1'b1; state_in = StIdle;
            end else begin
               cmd.pop_right = 1'b1; state_in = StLeft;
            end
         end
         StLeft: begin cmd.pop_left = 1'b1; state_in = StAlu; end
         StAlu:  begin cmd.start_alu = 1'b1; state_in = StWait; end
         StWait: if (status.alu_done) begin
            cmd.push_res = 1'b1; state_in = StIdle;
         end
         StEnd: state_in = StOut;
         StOut: if (rsp_ready) begin
            cmd.clear_expr = 1'b1; state_in = StIdle;
         end
         default: state_in = StIdle;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= StIdle;
      else       state_ff <= state_in;
   end

   // an accepted item always leaves idle
   a_leave: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> state_ff == StDec) else $error("item not taken");
   // result only follows an end-of-expression pop
   a_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff) == StEnd) else $error("stray result");
   // never ready while a result waits
   a_excl: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid)) else $error("ready with result pending");

endmodule

// ----- sv/postfix_expression_evaluator_top.sv -----
// Digits and brackets go through framing only; operators pop, run the ALU and push.
// The 32-step divider and square-and-multiply unit set the longest items.
// End of expression: the zero byte pops the answer, which is then held valid until taken.
// One item is processed at a time; the next is taken after the previous completes.
// Synchronous active-high reset empties the stack and clears the flags;
// stack contents are undefined until written.
module postfix_expression_evaluator_top
   import pee_pkg::*;
#(
   parameter int STACK_DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_symbol,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic signed [31:0] rsp_answer,
   output logic        rsp_stack_underflow,
   output logic        rsp_stack_overflow,
   output logic        rsp_divide_by_zero
);

   pee_cmd_type    cmd;
   pee_status_type status;
   logic [31:0]    answer;
   logic [2:0]     flags;

   pee_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready,
      .status, .cmd
   );

   pee_datapath #(.STACK_DEPTH(STACK_DEPTH)) u_dp (
      .clock, .reset, .symbol(req_symbol), .cmd, .status, .answer, .flags
   );

   assign rsp_answer          = answer;
   assign rsp_stack_underflow = flags[0];
   assign rsp_stack_overflow  = flags[1];
   assign rsp_divide_by_zero  = flags[2];

endmodule

// ----- bench/postfix_expression_evaluator_top_tb.sv -----
// Self-checking testbench of the postfix expression evaluator.
module postfix_expression_evaluator_top_tb
   import pee_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH = 16;

   typedef struct packed {
      logic [31:0] answer;
      logic        underflow;
      logic        overflow;
      logic        div_zero;
   } eval_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_symbol = 8'h00;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic signed [31:0] rsp_answer;
   logic        rsp_stack_underflow;
   logic        rsp_stack_overflow;
   logic        rsp_divide_by_zero;

   // predictor state
   logic [31:0] opnd_stack [DEPTH];
   int unsigned opnd_count;
   logic [31:0] num_acc;
   logic        in_frame;
   logic        num_stopped;
   logic [2:0]  err_flags;

   eval_result_type answers_due [$];
   int unsigned  error_count;
   int unsigned  answers_seen;
   int unsigned  items_sent;
   bit           quiet_rsp;
   bit           quiet_req;

   postfix_expression_evaluator_top #(.STACK_DEPTH(DEPTH)) dut (.*);

   // clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // guard against a hang
   initial begin
      #4000000;
      $display("TB_ERROR");
      $finish;
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      error_count++;
      $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
   endtask

   function automatic void stack_push(input logic [31:0] v);
      if (opnd_count >= DEPTH) err_flags[1] = 1'b1;
      else begin
         opnd_stack[opnd_count] = v;
         opnd_count++;
      end
   endfunction

   function automatic logic [31:0] stack_pop();
      if (opnd_count == 0) begin
         err_flags[0] = 1'b1;
         return PopEmpty;
      end
      opnd_count--;
      return opnd_stack[opnd_count];
   endfunction

   function automatic logic [31:0] int_power(input logic [31:0] b, input logic [31:0] e);
      logic [31:0] acc;
      logic [31:0] sq;
      acc = 32'd1;
      sq = b;
      if (e[31]) begin
         if (b == 32'd1) return 32'd1;
         if (b == 32'hFFFF_FFFF) return e[0] ? 32'hFFFF_FFFF : 32'd1;
         return 32'd0;
      end
      while (e != 0) begin
         if (e[0]) acc = acc * sq;
         sq = sq * sq;
         e = e >> 1;
      end
      return acc;
   endfunction

   // works out the effect of one accepted symbol
   function automatic void evaluate_symbol(input logic [7:0] sym);
      logic [31:0] rgt;
      logic [31:0] lft;
      logic [31:0] res;
      logic signed [63:0] sa;
      logic signed [63:0] sb;
      eval_result_type r;
      if (sym == SymEnd) begin
         r.answer = stack_pop();
         r.underflow = err_flags[0];
         r.overflow = err_flags[1];
         r.div_zero = err_flags[2];
         answers_due.push_back(r);
         opnd_count = 0;
         err_flags = '0;
         num_acc = '0;
         in_frame = 1'b0;
         num_stopped = 1'b0;
         return;
      end
      if (in_frame) begin
         if (sym == SymClose) begin
            stack_push(num_acc);
            in_frame = 1'b0;
            num_acc = '0;
            num_stopped = 1'b0;
         end else if (!num_stopped && sym >= "0" && sym <= "9") begin
            num_acc = num_acc * 32'd10 + 32'(sym - "0");
         end else begin
            num_stopped = 1'b1;
         end
         return;
      end
      if (sym == SymOpen) begin
         in_frame = 1'b1;
         num_acc = '0;
         num_stopped = 1'b0;
         return;
      end
      rgt = stack_pop();
      lft = stack_pop();
      sa = 64'(signed'(lft));
      sb = 64'(signed'(rgt));
      case (sym)
         SymAdd: stack_push(lft + rgt);
         SymSub: stack_push(lft - rgt);
         SymMul: stack_push(lft * rgt);
         SymDiv, SymMod: begin
            if (rgt == 0) begin
               err_flags[2] = 1'b1;
               res = '0;
            end else if (sym == SymDiv) res = 32'(sa / sb);
            else res = 32'(sa % sb);
            stack_push(res);
         end
         SymPow: stack_push(int_power(lft, rgt));
         default: ;
      endcase
   endfunction

   // send one symbol, with random idle before it
   task automatic send_symbol(input logic [7:0] sym);
      while (!quiet_req && $urandom_range(99) < 11) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_symbol <= sym;
      do @(posedge clock); while (!req_ready);
      evaluate_symbol(sym);
      items_sent++;
   endtask

   // result side: random stalls and field checks
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            eval_result_type want;
            answers_seen++;
            if (answers_due.size() == 0) report_mismatch("unexpected item", rsp_answer, 32'd0);
            else begin
               want = answers_due.pop_front();
               if (rsp_answer !== want.answer)
                  report_mismatch("answer", rsp_answer, want.answer);
               if (rsp_stack_underflow !== want.underflow)
                  report_mismatch("underflow", 32'(rsp_stack_underflow), 32'(want.underflow));
               if (rsp_stack_overflow !== want.overflow)
                  report_mismatch("overflow", 32'(rsp_stack_overflow), 32'(want.overflow));
               if (rsp_divide_by_zero !== want.div_zero)
                  report_mismatch("div zero", 32'(rsp_divide_by_zero), 32'(want.div_zero));
            end
         end
         rsp_ready <= quiet_rsp || ($urandom_range(99) >= 11);
      end
   end

   task automatic send_number(input logic [31:0] v);
      string s;
      s = $sformatf("%0d", v);
      send_symbol(SymOpen);
      foreach (s[i]) send_symbol(s[i]);
      send_symbol(SymClose);
   endtask

   task automatic send_negative(input int v);
      send_number(0);
      send_number(32'(v));
      send_symbol(SymSub);
   endtask

   task automatic test_directed();
      // extremes, every operator, wraps
      send_number(32'd4294967295); send_number(32'd1); send_symbol(SymAdd);
      send_symbol(SymEnd);
      send_symbol(SymOpen); send_symbol("9"); send_symbol("x"); send_symbol("7");
      send_symbol(SymOpen); send_symbol(SymClose);
      send_symbol(SymOpen); send_symbol(SymClose); send_symbol(SymMul);
      send_symbol(SymEnd);
      send_number(7); send_number(0); send_symbol(SymDiv);
      send_number(3); send_number(0); send_symbol(SymMod); send_symbol(SymSub);
      send_symbol(SymEnd);
      send_number(32'h8000_0000); send_number(32'hFFFF_FFFF); send_symbol(SymDiv);
      send_symbol(SymEnd);
      send_symbol(SymAdd); send_symbol(8'hFF); send_symbol(SymClose); send_symbol(SymEnd);
      send_number(3); send_number(32'hFFFF_FFFD); send_symbol(SymPow); send_symbol(SymEnd);
      send_number(32'hFFFF_FFFF); send_number(32'hFFFF_FFFD); send_symbol(SymPow);
      send_symbol(SymEnd);
      send_number(0); send_number(0); send_symbol(SymPow); send_symbol(SymEnd);
      send_number(32'h8000_0000); send_number(32'hFFFF_FFFF); send_symbol(SymMod);
      send_symbol(SymEnd);
      send_symbol(SymOpen); send_symbol("5"); send_symbol(SymEnd);
      for (int i = 0; i < DEPTH + 2; i++) send_number(i);
      send_symbol(SymEnd);
   endtask

   // well-formed expressions with random content
   task automatic test_random_expressions(input int unsigned budget);
      logic [7:0] ops [6];
      int depth;
      ops = '{SymAdd, SymSub, SymMul, SymDiv, SymMod, SymPow};
      while (items_sent < budget) begin
         quiet_req = quiet_rsp || ($urandom_range(9) == 0);
         depth = 0;
         repeat ($urandom_range(12, 1)) begin
            if (depth < 2 || $urandom_range(2) == 0) begin
               case ($urandom_range(4))
                  0: send_number($urandom);
                  1: send_negative($urandom_range(40));
                  2: send_number($urandom_range(3));
                  default: send_number($urandom_range(99));
               endcase
               depth++;
            end else begin
               send_symbol(ops[$urandom_range(5)]);
               depth--;
            end
            // occasional noise
            if ($urandom_range(24) == 0) send_symbol(8'($urandom));
         end
         send_symbol(SymEnd);
      end
      quiet_req = 1'b0;
   endtask

   // raw random bytes, biased towards meaningful symbols
   task automatic test_random_noise(input int unsigned count);
      repeat (count) begin
         if ($urandom_range(3) == 0) send_symbol(8'($urandom));
         else send_symbol(8'("0" + $urandom_range(9) + ($urandom_range(1) ? 8'h2B - "0" : 0)));
         if ($urandom_range(15) == 0) send_symbol(SymEnd);
      end
      send_symbol(SymEnd);
   endtask

   initial begin
      int unsigned wait_cycles;
      opnd_count = 0; num_acc = '0; in_frame = 0; num_stopped = 0; err_flags = '0;
      error_count = 0; answers_seen = 0; items_sent = 0;
      quiet_rsp = 0; quiet_req = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random_noise(150);
      quiet_rsp = 1'b1;
      test_random_expressions(items_sent + 300);
      quiet_rsp = 1'b0;
      test_random_expressions(items_sent + 900);
      req_valid <= 1'b0;
      // drain
      wait_cycles = 0;
      while (answers_due.size() != 0 && wait_cycles < 10000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (50) @(posedge clock);
      if (answers_due.size() != 0)
         report_mismatch("missing items", 32'(answers_due.size()), 32'd0);
      $display("covered %0d symbols and %0d answers", items_sent, answers_seen);
      if (error_count == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end

endmodule

// ----- postfix_expression_evaluator_top.f -----
sv/pee_pkg.sv
sv/pee_datapath.sv
sv/pee_ctrl.sv
sv/postfix_expression_evaluator_top.sv
bench/postfix_expression_evaluator_top_tb.sv
